### src/mft_pkg.sv
// Package: shared types and constants for the mesh flux tally.
package mft_pkg;

  localparam int unsigned CellsX = 16;
  localparam int unsigned CellsY = 16;
  localparam int unsigned CellsZ = 16;
  localparam int unsigned Groups = 4;
  localparam int unsigned NumBins = Groups * CellsX * CellsY * CellsZ;
  localparam int unsigned BinW = $clog2(NumBins);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrW = $clog2(QueueDepth);

  localparam logic [63:0] SMax = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_SCORE = 2'd0,
    OP_RECORD = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_LOW_X = 3'd0,
    CFG_LOW_Y = 3'd1,
    CFG_LOW_Z = 3'd2,
    CFG_INV_X = 3'd3,
    CFG_INV_Y = 3'd4,
    CFG_INV_Z = 3'd5
  } cfg_idx_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t op;
    logic hit;
    logic [BinW-1:0] addr;
    logic [31:0] weight;
    logic [31:0] total_xs;
    logic [31:0] gen_n;
    logic rd_oob;
  } cmd_t;

  typedef struct packed {
    logic in_mesh;
    logic [63:0] mean_value;
    logic [63:0] variance_value;
  } res_t;

  typedef enum logic [3:0] {
    BK_INIT,
    BK_IDLE,
    BK_DIV,
    BK_SCORE_RD,
    BK_SCORE_WR,
    BK_REC_RD,
    BK_REC_DIV1,
    BK_REC_MUL,
    BK_REC_DIV2,
    BK_REC_WR,
    BK_CLEAR,
    BK_READ_RD,
    BK_OUT
  } bk_state_t;

endpackage

### src/mft_if.sv
// Interfaces: valid/ready channels for input items and results.
interface mft_in_if;
  logic valid;
  logic ready;
  logic [1:0] operation;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [7:0] energy_group;
  logic [31:0] weight;
  logic [31:0] total_xs;
  logic [31:0] generation_count;
  logic [13:0] bin_index;
  modport source(output valid, operation, pos_x, pos_y, pos_z, energy_group, weight,
                 total_xs, generation_count, bin_index, input ready);
  modport sink(input valid, operation, pos_x, pos_y, pos_z, energy_group, weight,
               total_xs, generation_count, bin_index, output ready);
endinterface

interface mft_out_if;
  logic valid;
  logic ready;
  logic in_mesh;
  logic signed [63:0] mean_value;
  logic signed [63:0] variance_value;
  logic done_res;
  modport source(output valid, in_mesh, mean_value, variance_value, done_res, input ready);
  modport sink(input valid, in_mesh, mean_value, variance_value, done_res, output ready);
endinterface

### src/mft_div.sv
// Radix-2 restoring divider: 64-bit unsigned dividend by 64-bit divisor.
module mft_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] sh;
  logic [64:0] diff;

  always_comb begin
    sh = {rem_r[63:0], q_r[63]};
    diff = sh - {1'b0, dvs_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (diff[64]) begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end else begin
        rem_nxt = diff;
        q_nxt = {q_r[62:0], 1'b1};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (start) dvs_r <= divisor;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = q_r;
endmodule

### src/mft_front.sv
// Front end: bins each item into a command (cell index math, group check).
module mft_front (
  input  logic                  clk,
  input  logic                  rst_n,
  mft_in_if.sink                in_ch,
  input  logic signed [31:0]    low_x,
  input  logic signed [31:0]    low_y,
  input  logic signed [31:0]    low_z,
  input  logic [31:0]           inv_x,
  input  logic [31:0]           inv_y,
  input  logic [31:0]           inv_z,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output mft_pkg::cmd_t         cmd
);
  // Stage 1 registers: differences and item payload
  logic        s1_valid_r;
  logic [32:0] mag_r [3];
  logic        neg_r [3];
  logic [31:0] inv_r [3];
  logic [1:0]  op_r;
  logic [7:0]  grp_r;
  logic [31:0] w_r, xs_r, n_r;
  logic [13:0] bin_r;
  // Stage 2 registers: products
  logic        s2_valid_r;
  logic [63:0] p_r [3];
  logic        neg2_r [3];
  logic [1:0]  op2_r;
  logic [7:0]  grp2_r;
  logic [31:0] w2_r, xs2_r, n2_r;
  logic [13:0] bin2_r;

  logic signed [32:0] d [3];
  logic        adv2, adv1;
  logic [8:0]  idx [3];
  logic        ok [3];
  logic [31:0] flat;

  assign adv2 = !s2_valid_r || cmd_ready;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ch.ready = adv1;

  always_comb begin
    d[0] = 33'(in_ch.pos_x) - 33'(low_x);
    d[1] = 33'(in_ch.pos_y) - 33'(low_y);
    d[2] = 33'(in_ch.pos_z) - 33'(low_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_ch.valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
    if (adv1) begin
      for (int a = 0; a < 3; a++) begin
        neg_r[a] <= d[a][32];
        mag_r[a] <= d[a][32] ? 33'(-d[a]) : d[a];
      end
      inv_r[0] <= inv_x;
      inv_r[1] <= inv_y;
      inv_r[2] <= inv_z;
      op_r <= in_ch.operation;
      grp_r <= in_ch.energy_group;
      w_r <= in_ch.weight;
      xs_r <= in_ch.total_xs;
      n_r <= in_ch.generation_count;
      bin_r <= in_ch.bin_index;
    end
    if (adv2) begin
      for (int a = 0; a < 3; a++) begin
        p_r[a] <= 64'({31'd0, mag_r[a]} * {32'd0, inv_r[a]});
        neg2_r[a] <= neg_r[a];
      end
      op2_r <= op_r;
      grp2_r <= grp_r;
      w2_r <= w_r;
      xs2_r <= xs_r;
      n2_r <= n_r;
      bin2_r <= bin_r;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      idx[a] = '0;
      ok[a] = 1'b0;
      if (neg2_r[a]) begin
        ok[a] = (p_r[a] == 64'd0);
      end else if (p_r[a][63:32] < 32'((a == 0) ? mft_pkg::CellsX :
                                       (a == 1) ? mft_pkg::CellsY : mft_pkg::CellsZ)) begin
        ok[a] = 1'b1;
        idx[a] = p_r[a][40:32];
      end
    end
    flat = ((32'(grp2_r) * 32'(mft_pkg::CellsX) + 32'(idx[0])) * 32'(mft_pkg::CellsY)
            + 32'(idx[1])) * 32'(mft_pkg::CellsZ) + 32'(idx[2]);
    cmd.op = mft_pkg::op_t'(op2_r);
    cmd.hit = ok[0] && ok[1] && ok[2] && (32'(grp2_r) < 32'(mft_pkg::Groups));
    cmd.addr = (op2_r == mft_pkg::OP_READ) ? bin2_r[mft_pkg::BinW-1:0]
                                           : flat[mft_pkg::BinW-1:0];
    cmd.weight = w2_r;
    cmd.total_xs = xs2_r;
    cmd.gen_n = (n2_r == 32'd0) ? 32'd1 : n2_r;
    cmd.rd_oob = (32'(bin2_r) >= 32'(mft_pkg::NumBins));
  end

  assign cmd_valid = s2_valid_r;
endmodule

### src/mft_queue.sv
// Command queue between front and back ends.
module mft_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  mft_pkg::cmd_t  wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output mft_pkg::cmd_t  rd_data
);
  mft_pkg::cmd_t slot_r [mft_pkg::QueueDepth];
  logic [mft_pkg::QPtrW-1:0] wp_r, rp_r;
  logic [mft_pkg::QPtrW:0]   cnt_r;
  logic do_wr, do_rd;

  assign wr_ready = (cnt_r != (mft_pkg::QPtrW+1)'(mft_pkg::QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;
  assign rd_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (mft_pkg::QPtrW+1)'(do_wr) - (mft_pkg::QPtrW+1)'(do_rd);
    end
    if (do_wr) slot_r[wp_r] <= wr_data;
  end
endmodule

### src/mft_back.sv
// Back end: tally, mean and variance memories with the score/record/clear/read sequencer.
module mft_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mft_pkg::cmd_t  cmd,
  mft_out_if.source      out_ch
);
  localparam int unsigned BW = mft_pkg::BinW;

  logic [63:0] tally_mem [mft_pkg::NumBins];
  logic [63:0] mean_mem  [mft_pkg::NumBins];
  logic [63:0] var_mem   [mft_pkg::NumBins];

  mft_pkg::bk_state_t st_r, st_nxt;
  mft_pkg::cmd_t      c_r, c_nxt;
  logic [BW:0]        ptr_r, ptr_nxt;
  logic [63:0]        t_rd, m_rd, v_rd;
  logic [63:0]        a_r, a_nxt;    // score or new mean
  logic [63:0]        b_r, b_nxt;    // sign of the value being divided
  logic [63:0]        m1_r, m1_nxt, m2_r, m2_nxt;
  logic               neg_r, neg_nxt;
  mft_pkg::res_t      res_r, res_nxt;
  logic               ov_r, ov_nxt;

  logic               rd_en;
  logic [BW-1:0]      rd_addr;
  logic               wr_en, clr_wr;
  logic [BW-1:0]      wr_addr;
  logic [63:0]        wt_data, wm_data, wv_data;
  logic               wr_t, wr_mv;

  logic               div_start, div_busy, div_done;
  logic [63:0]        div_a, div_b, div_q;

  mft_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // 64x64 product as four 32x32 partials, one per cycle in the MUL state
  logic [1:0]  mph_r, mph_nxt;
  logic [63:0] pp;
  logic [127:0] acc_r, acc_nxt;

  logic signed [63:0] d1, d2, tsum, vdiff, sq;
  logic [63:0] hi_sat;

  always_comb begin
    case (mph_r)
      2'd0: pp = {32'd0, m1_r[31:0]} * {32'd0, m2_r[31:0]};
      2'd1: pp = {32'd0, m1_r[31:0]} * {32'd0, m2_r[63:32]};
      2'd2: pp = {32'd0, m1_r[63:32]} * {32'd0, m2_r[31:0]};
      default: pp = {32'd0, m1_r[63:32]} * {32'd0, m2_r[63:32]};
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    c_nxt = c_r;
    ptr_nxt = ptr_r;
    a_nxt = a_r;
    b_nxt = b_r;
    m1_nxt = m1_r;
    m2_nxt = m2_r;
    neg_nxt = neg_r;
    res_nxt = res_r;
    ov_nxt = 1'b0;
    mph_nxt = mph_r;
    acc_nxt = acc_r;
    cmd_ready = 1'b0;
    rd_en = 1'b0;
    rd_addr = c_r.addr;
    wr_en = 1'b0;
    wr_t = 1'b0;
    wr_mv = 1'b0;
    clr_wr = 1'b0;
    wr_addr = c_r.addr;
    wt_data = '0;
    wm_data = a_r;
    wv_data = '0;
    div_start = 1'b0;
    div_a = '0;
    div_b = '0;
    d1 = $signed(t_rd) - $signed(m_rd);
    d2 = '0;
    tsum = '0;
    vdiff = '0;
    sq = '0;
    hi_sat = '0;
    case (st_r)
      mft_pkg::BK_INIT: begin
        // reset sweep zeroes all three stores
        clr_wr = 1'b1;
        wr_t = 1'b1;
        wr_mv = 1'b1;
        wr_addr = ptr_r[BW-1:0];
        wm_data = '0;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[BW-1:0] == BW'(mft_pkg::NumBins - 1)) st_nxt = mft_pkg::BK_IDLE;
      end
      mft_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          c_nxt = cmd;
          ptr_nxt = '0;
          res_nxt = '0;
          case (cmd.op)
            mft_pkg::OP_SCORE: begin
              res_nxt.in_mesh = cmd.hit;
              if (!cmd.hit) st_nxt = mft_pkg::BK_OUT;
              else if (cmd.total_xs == 32'd0) begin
                a_nxt = mft_pkg::SMax;
                st_nxt = mft_pkg::BK_SCORE_RD;
              end else begin
                div_start = 1'b1;
                div_a = {cmd.weight, 32'd0};
                div_b = {32'd0, cmd.total_xs};
                st_nxt = mft_pkg::BK_DIV;
              end
            end
            mft_pkg::OP_RECORD: st_nxt = mft_pkg::BK_REC_RD;
            mft_pkg::OP_CLEAR: st_nxt = mft_pkg::BK_CLEAR;
            default: st_nxt = cmd.rd_oob ? mft_pkg::BK_OUT : mft_pkg::BK_READ_RD;
          endcase
        end
      end
      mft_pkg::BK_DIV: begin
        if (div_done) begin
          a_nxt = div_q[63] ? mft_pkg::SMax : div_q;
          st_nxt = mft_pkg::BK_SCORE_RD;
        end
      end
      mft_pkg::BK_SCORE_RD: begin
        rd_en = 1'b1;
        st_nxt = mft_pkg::BK_SCORE_WR;
      end
      mft_pkg::BK_SCORE_WR: begin
        // t, s both nonnegative; sum in 64 bits unsigned never wraps past 2^64
        tsum = $signed(t_rd + a_r);
        wr_t = 1'b1;
        wt_data = tsum[63] ? mft_pkg::SMax : tsum;
        st_nxt = mft_pkg::BK_OUT;
      end
      mft_pkg::BK_REC_RD: begin
        rd_en = 1'b1;
        rd_addr = ptr_r[BW-1:0];
        st_nxt = mft_pkg::BK_REC_DIV1;
        neg_nxt = 1'b0;
      end
      mft_pkg::BK_REC_DIV1: begin
        // on entry: data from memories valid; launch delta/n
        if (!div_busy && !neg_r) begin
          div_start = 1'b1;
          div_a = d1[63] ? 64'(-d1) : d1;
          div_b = {32'd0, c_r.gen_n};
          neg_nxt = 1'b1;
          m1_nxt = d1[63] ? 64'(-d1) : d1;
          b_nxt = {63'd0, d1[63]};
        end else if (div_done) begin
          a_nxt = $signed(m_rd) + (b_r[0] ? $signed(-div_q) : $signed(div_q));
          d2 = $signed(t_rd) - ($signed(m_rd) + (b_r[0] ? $signed(-div_q) : $signed(div_q)));
          m2_nxt = d2[63] ? 64'(-d2) : d2;
          mph_nxt = 2'd0;
          acc_nxt = '0;
          st_nxt = mft_pkg::BK_REC_MUL;
        end
      end
      mft_pkg::BK_REC_MUL: begin
        case (mph_r)
          2'd0: acc_nxt = acc_r + {64'd0, pp};
          2'd1, 2'd2: acc_nxt = acc_r + {32'd0, pp, 32'd0};
          default: acc_nxt = acc_r + {pp, 64'd0};
        endcase
        mph_nxt = mph_r + 2'd1;
        if (mph_r == 2'd3) begin
          neg_nxt = 1'b0;
          st_nxt = mft_pkg::BK_REC_DIV2;
        end
      end
      mft_pkg::BK_REC_DIV2: begin
        hi_sat = acc_r[127:64];
        sq = (hi_sat >= 64'h8000_0000) ? mft_pkg::SMax : acc_r[95:32];
        vdiff = sq - $signed(v_rd);
        if (!neg_r) begin
          div_start = 1'b1;
          div_a = vdiff[63] ? 64'(-vdiff) : vdiff;
          div_b = {32'd0, c_r.gen_n};
          neg_nxt = 1'b1;
          b_nxt = {63'd0, vdiff[63]};
        end else if (div_done) begin
          m1_nxt = $signed(v_rd) + (b_r[0] ? $signed(-div_q) : $signed(div_q));
          st_nxt = mft_pkg::BK_REC_WR;
        end
      end
      mft_pkg::BK_REC_WR: begin
        wr_mv = 1'b1;
        wr_addr = ptr_r[BW-1:0];
        wm_data = a_r;
        wv_data = m1_r;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[BW-1:0] == BW'(mft_pkg::NumBins - 1)) st_nxt = mft_pkg::BK_OUT;
        else st_nxt = mft_pkg::BK_REC_RD;
      end
      mft_pkg::BK_CLEAR: begin
        wr_t = 1'b1;
        wr_addr = ptr_r[BW-1:0];
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r[BW-1:0] == BW'(mft_pkg::NumBins - 1)) st_nxt = mft_pkg::BK_OUT;
      end
      mft_pkg::BK_READ_RD: begin
        rd_en = 1'b1;
        ov_nxt = 1'b1;
        if (ov_r) begin
          res_nxt.mean_value = m_rd;
          res_nxt.variance_value = v_rd;
          st_nxt = mft_pkg::BK_OUT;
        end
      end
      mft_pkg::BK_OUT: begin
        if (out_ch.ready) st_nxt = mft_pkg::BK_IDLE;
      end
      default: st_nxt = mft_pkg::BK_IDLE;
    endcase
    wr_en = wr_t || wr_mv || clr_wr;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      t_rd <= tally_mem[rd_addr];
      m_rd <= mean_mem[rd_addr];
      v_rd <= var_mem[rd_addr];
    end
    if (wr_en && wr_t) tally_mem[wr_addr] <= wt_data;
    if (wr_en && wr_mv) begin
      mean_mem[wr_addr] <= wm_data;
      var_mem[wr_addr] <= wv_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= mft_pkg::BK_INIT;
      ptr_r <= '0;
      ov_r <= 1'b0;
      neg_r <= 1'b0;
      mph_r <= '0;
    end else begin
      st_r <= st_nxt;
      ptr_r <= ptr_nxt;
      ov_r <= ov_nxt;
      neg_r <= neg_nxt;
      mph_r <= mph_nxt;
    end
    c_r <= c_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    m1_r <= m1_nxt;
    m2_r <= m2_nxt;
    res_r <= res_nxt;
    acc_r <= acc_nxt;
  end

  assign out_ch.valid = (st_r == mft_pkg::BK_OUT);
  assign out_ch.in_mesh = res_r.in_mesh;
  assign out_ch.mean_value = res_r.mean_value;
  assign out_ch.variance_value = res_r.variance_value;
  assign out_ch.done_res = 1'b1;
endmodule

### src/mesh_flux_tally_running_stats_top.sv
// Top level: mesh flux tally with running mean and variance per bin.
// Score: a bit-serial division (none for a zero cross section) plus a memory
// read-modify-write; read: a memory read; clear: a sweep over all NumBins bins;
// record: two serial divisions and a 4-step multiply per bin, over every bin.
// Throughput: one item at a time in the back end; the front bins the next
// items into a 4-entry queue meanwhile. After reset the back end zeroes all
// NumBins (16384) bins of the three stores before taking items.
module mesh_flux_tally_running_stats_top (
  input  logic        clk,
  input  logic        rst_n,
  mft_in_if.sink      in_ch,
  mft_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  logic signed [31:0] low_x_r, low_y_r, low_z_r;
  logic [31:0] inv_x_r, inv_y_r, inv_z_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_x_r <= '0;
      low_y_r <= '0;
      low_z_r <= '0;
      inv_x_r <= 32'd65536;
      inv_y_r <= 32'd65536;
      inv_z_r <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        mft_pkg::CFG_LOW_X: low_x_r <= cfg_wdata;
        mft_pkg::CFG_LOW_Y: low_y_r <= cfg_wdata;
        mft_pkg::CFG_LOW_Z: low_z_r <= cfg_wdata;
        mft_pkg::CFG_INV_X: inv_x_r <= cfg_wdata;
        mft_pkg::CFG_INV_Y: inv_y_r <= cfg_wdata;
        mft_pkg::CFG_INV_Z: inv_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic          f_valid, f_ready, q_valid, q_ready;
  mft_pkg::cmd_t f_cmd, q_cmd;

  // front: cell binning, two pipeline stages
  mft_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .low_x(low_x_r), .low_y(low_y_r), .low_z(low_z_r),
    .inv_x(inv_x_r), .inv_y(inv_y_r), .inv_z(inv_z_r),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // decoupling queue
  mft_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  // back: memories and sequencer, result held until transferred
  mft_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_ch(out_ch)
  );
endmodule

### dv/mft_tb_pkg.sv
// Testbench package: stimulus item type for the mesh flux tally bench.
`timescale 1ns / 100ps
package mft_tb_pkg;

  typedef struct {
    mft_pkg::op_t     op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [7:0]       group;
    logic [31:0]      weight;
    logic [31:0]      total_xs;
    logic [31:0]      gen_count;
    logic [13:0]      bin;
  } particle_cmd_t;

  typedef struct {
    logic        in_mesh;
    logic [63:0] mean;
    logic [63:0] variance;
  } bin_stats_t;
endpackage

### dv/tb_mesh_flux_tally_running_stats_top.sv
// Testbench top: drives mixed score/record/clear/read traffic and checks every result.
`timescale 1ns / 100ps
module tb_mesh_flux_tally_running_stats_top;

  localparam longint SMaxL = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int     RunLimit = 20_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  mft_in_if  in_ch();
  mft_out_if out_ch();

  mesh_flux_tally_running_stats_top DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block: configuration and the three per-bin stores.
  longint      low_sh [3];
  logic [31:0] inv_sh [3];
  longint      gen_tally [mft_pkg::NumBins];
  longint      run_mean [mft_pkg::NumBins];
  longint      run_var [mft_pkg::NumBins];

  mft_tb_pkg::particle_cmd_t pend_q[$];
  mft_tb_pkg::bin_stats_t    stats_q[$];
  mft_tb_pkg::particle_cmd_t cur_cmd;
  bit            cmd_held;
  bit            cmd_taken;
  int            burst_left, gap_left;
  int            n_fail, n_results, n_accepted, n_hits, n_records;
  int            cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Cell index on one axis, -1 when rejected.
  function automatic int axis_bin(longint pos, longint low, logic [31:0] inv, int cnt);
    longint      d;
    logic [63:0] mag, p;
    d = pos - low;
    mag = (d < 0) ? -d : d;
    p = mag * {32'b0, inv};
    if (d < 0) return (p != 0) ? -1 : 0;
    if (p[63:32] >= cnt) return -1;
    return int'(p[63:32]);
  endfunction

  // Q32.32 product of two magnitudes, saturating.
  function automatic longint qmul_sat(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:95] != 0) return SMaxL;
    return longint'(p[95:32]);
  endfunction

  function automatic mft_tb_pkg::bin_stats_t tally_step(mft_tb_pkg::particle_cmd_t c);
    mft_tb_pkg::bin_stats_t r;
    int          i, j, k, a;
    logic [63:0] q;
    longint      s, nd, d1, avg, d2, prod;
    r = '{1'b0, 64'd0, 64'd0};
    case (c.op)
      mft_pkg::OP_SCORE: begin
        i = axis_bin(longint'(c.pos_x), low_sh[0], inv_sh[0], mft_pkg::CellsX);
        j = axis_bin(longint'(c.pos_y), low_sh[1], inv_sh[1], mft_pkg::CellsY);
        k = axis_bin(longint'(c.pos_z), low_sh[2], inv_sh[2], mft_pkg::CellsZ);
        if (i >= 0 && j >= 0 && k >= 0 && c.group < mft_pkg::Groups) begin
          q = (c.total_xs == 0) ? mft_pkg::SMax
                                : ({c.weight, 32'b0} / {32'b0, c.total_xs});
          s = (q > mft_pkg::SMax) ? SMaxL : longint'(q);
          a = ((int'(c.group) * mft_pkg::CellsX + i) * mft_pkg::CellsY + j)
              * mft_pkg::CellsZ + k;
          gen_tally[a] = (gen_tally[a] > SMaxL - s) ? SMaxL : gen_tally[a] + s;
          r.in_mesh = 1'b1;
        end
      end
      mft_pkg::OP_RECORD: begin
        nd = (c.gen_count == 0) ? 64'sd1 : longint'({32'b0, c.gen_count});
        for (int b = 0; b < mft_pkg::NumBins; b++) begin
          d1 = gen_tally[b] - run_mean[b];
          avg = run_mean[b] + d1 / nd;
          d2 = gen_tally[b] - avg;
          prod = qmul_sat((d1 < 0) ? -d1 : d1, (d2 < 0) ? -d2 : d2);
          run_mean[b] = avg;
          run_var[b] = run_var[b] + (prod - run_var[b]) / nd;
        end
      end
      mft_pkg::OP_CLEAR: foreach (gen_tally[b]) gen_tally[b] = 0;
      default: if (c.bin < mft_pkg::NumBins) begin
        r.mean = run_mean[c.bin];
        r.variance = run_var[c.bin];
      end
    endcase
    return r;
  endfunction

  // Fully random fields; callers override what matters.
  function automatic mft_tb_pkg::particle_cmd_t rand_cmd(mft_pkg::op_t op);
    mft_tb_pkg::particle_cmd_t c;
    c.op = op;
    c.pos_x = $urandom; c.pos_y = $urandom; c.pos_z = $urandom;
    c.group = $urandom; c.weight = $urandom; c.total_xs = $urandom;
    c.gen_count = $urandom; c.bin = $urandom;
    return c;
  endfunction

  // Position on one axis aimed at (or just around) the mesh span; one in eight fully random.
  function automatic logic [31:0] aim_axis(int ax, int cnt);
    logic [63:0] span;
    if (inv_sh[ax] == 0 || $urandom_range(0, 7) == 0) return $urandom;
    span = ({32'b0, 32'(cnt + 1)} << 32) / inv_sh[ax];
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    return 32'(low_sh[ax] + longint'({$urandom, $urandom} % (span + 1)) - 2);
  endfunction

  function automatic mft_tb_pkg::particle_cmd_t score_at(logic signed [31:0] x,
                                                         logic signed [31:0] y,
                                                         logic signed [31:0] z, logic [7:0] g,
                                                         logic [31:0] w, logic [31:0] xs);
    mft_tb_pkg::particle_cmd_t c;
    c = rand_cmd(mft_pkg::OP_SCORE);
    c.pos_x = x; c.pos_y = y; c.pos_z = z; c.group = g; c.weight = w; c.total_xs = xs;
    return c;
  endfunction

  function automatic mft_tb_pkg::particle_cmd_t op_cmd(mft_pkg::op_t op, logic [31:0] n,
                                                       logic [13:0] bin);
    mft_tb_pkg::particle_cmd_t c;
    c = rand_cmd(op);
    c.gen_count = n;
    c.bin = bin;
    return c;
  endfunction

  task automatic cfg_write(mft_pkg::cfg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx < mft_pkg::CFG_INV_X) low_sh[idx] = longint'($signed(v));
    else inv_sh[idx - mft_pkg::CFG_INV_X] = v;
  endtask

  // Sender pause: nothing pending, nothing in flight, then a quiet margin.
  task automatic drain();
    while (pend_q.size() != 0 || cmd_held || stats_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic push_random(int cnt);
    mft_tb_pkg::particle_cmd_t c;
    int            sel;
    for (int n = 0; n < cnt; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 78) begin
        c = rand_cmd(mft_pkg::OP_SCORE);
        c.pos_x = aim_axis(0, mft_pkg::CellsX);
        c.pos_y = aim_axis(1, mft_pkg::CellsY);
        c.pos_z = aim_axis(2, mft_pkg::CellsZ);
        if ($urandom_range(0, 9) != 0) c.group = $urandom_range(0, mft_pkg::Groups - 1);
        if ($urandom_range(0, 3) != 0) c.total_xs = $urandom_range(32'h100, 32'h00FF_FFFF);
        if ($urandom_range(0, 3) != 0) c.weight = $urandom_range(0, 32'h0004_0000);
      end else if (sel < 92) begin
        c = rand_cmd(mft_pkg::OP_READ);
        if ($urandom_range(0, 1) != 0) c.bin = $urandom_range(0, 1023);
      end else if (sel < 96) begin
        c = rand_cmd(mft_pkg::OP_CLEAR);
      end else begin
        c = rand_cmd(mft_pkg::OP_SCORE);
      end
      pend_q.push_back(c);
    end
  endtask

  // Driver: bursts with random gaps; an offered item stays until its transfer.
  always @(negedge clk) begin
    bit nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (cmd_taken) begin
        cmd_taken = 1'b0;
        cmd_held = 1'b0;
      end
      if (!cmd_held) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() != 0) begin
          cur_cmd = pend_q.pop_front();
          cmd_held = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 30);
          end else begin
            burst_left--;
          end
        end
      end
      nxt = cmd_held;
      in_ch.valid <= nxt;
      if (nxt) begin
        in_ch.operation <= cur_cmd.op;
        in_ch.pos_x <= cur_cmd.pos_x;
        in_ch.pos_y <= cur_cmd.pos_y;
        in_ch.pos_z <= cur_cmd.pos_z;
        in_ch.energy_group <= cur_cmd.group;
        in_ch.weight <= cur_cmd.weight;
        in_ch.total_xs <= cur_cmd.total_xs;
        in_ch.generation_count <= cur_cmd.gen_count;
        in_ch.bin_index <= cur_cmd.bin;
      end
    end
  end

  // Receiver: stall rate is redrawn from four levels; one long hold-off fills the block.
  int  hold_cnt;
  bit  hold_done;
  int  stall_pct;
  always @(negedge clk) begin
    bit rdy;
    if (cycles % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      rdy = 1'b0;
    end else if (!hold_done && n_results >= 150) begin
      hold_done = 1'b1;
      hold_cnt = 3000;
      rdy = 1'b0;
    end else begin
      rdy = ($urandom_range(0, 99) >= stall_pct);
    end
    out_ch.ready <= rdy;
  end

  // Input transfers: predict in acceptance order.
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      stats_q.push_back(tally_step(cur_cmd));
      if (cur_cmd.op == mft_pkg::OP_RECORD) n_records++;
      n_accepted++;
      cmd_taken = 1'b1;
    end
    if (cycles > RunLimit) begin
      $display("tb_mesh_flux_tally_running_stats_top NOT OK");
      $finish;
    end
  end

  // Result transfers: compare with the oldest expectation.
  always @(posedge clk) begin
    mft_tb_pkg::bin_stats_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (stats_q.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
      end else begin
        e = stats_q.pop_front();
        if (e.in_mesh) n_hits++;
        if (out_ch.in_mesh !== e.in_mesh) begin
          $error("in_mesh exp %0d got %0d", e.in_mesh, out_ch.in_mesh);
          n_fail++;
        end
        if (out_ch.mean_value !== e.mean) begin
          $error("mean_value exp %h got %h", e.mean, out_ch.mean_value);
          n_fail++;
        end
        if (out_ch.variance_value !== e.variance) begin
          $error("variance_value exp %h got %h", e.variance, out_ch.variance_value);
          n_fail++;
        end
        if (out_ch.done_res !== 1'b1) begin
          $error("done_res exp 1 got %0d", out_ch.done_res);
          n_fail++;
        end
      end
    end
  end

  initial begin
    int waited;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.operation = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.energy_group = '0; in_ch.weight = '0; in_ch.total_xs = '0;
    in_ch.generation_count = '0; in_ch.bin_index = '0;
    out_ch.ready = 1'b0;
    low_sh = '{0, 0, 0};
    inv_sh = '{32'h1_0000, 32'h1_0000, 32'h1_0000};
    foreach (gen_tally[b]) begin
      gen_tally[b] = 0; run_mean[b] = 0; run_var[b] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset mesh: unit cells from the origin.
    pend_q.push_back(score_at(32'h1_8000, 32'h2_8000, 32'h3_8000, 0, 32'h1_0000, 32'h1_0000));
    pend_q.push_back(score_at(32'h1_0000, 32'h2_0000, 32'h3_0000, 0, 32'h3_0000, 32'h2_0000));
    pend_q.push_back(score_at(0, 0, 0, 3, 32'h1_0000, 0));          // divide by zero
    pend_q.push_back(score_at(0, 0, 0, 4, 32'h1_0000, 32'h1_0000)); // group too high
    pend_q.push_back(score_at(0, 0, 0, 255, 32'h1_0000, 32'h1_0000));
    pend_q.push_back(score_at(-1, 0, 0, 0, 32'h1_0000, 32'h1_0000)); // just below mesh
    pend_q.push_back(score_at(32'h10_0000, 0, 0, 0, 32'h1_0000, 32'h1_0000)); // past end
    pend_q.push_back(score_at(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'hFFFF_FFFF, 1));
    for (int n = 0; n < 3; n++)  // large quotient, then tally saturation
      pend_q.push_back(score_at(32'h5_0000, 32'h5_0000, 32'h5_0000, 1, 32'hFFFF_FFFF, 1));
    pend_q.push_back(score_at(32'hF_FFFF, 32'hF_FFFF, 32'hF_FFFF, 3, 0, 32'hFFFF_FFFF));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 1, 14'(((0 * 16 + 1) * 16 + 2) * 16 + 3)));
    pend_q.push_back(op_cmd(mft_pkg::OP_RECORD, 0, 0));  // zero count acts as one
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 1, 14'(((0 * 16 + 1) * 16 + 2) * 16 + 3)));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 1, 14'(((1 * 16 + 5) * 16 + 5) * 16 + 5)));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 1, 14'h3FFF));
    pend_q.push_back(op_cmd(mft_pkg::OP_CLEAR, 1, 0));
    drain();

    // Extremes: lowest bounds and zero reciprocal put every particle in cell 0.
    cfg_write(mft_pkg::CFG_LOW_X, 32'h8000_0000);
    cfg_write(mft_pkg::CFG_LOW_Y, 32'h8000_0000);
    cfg_write(mft_pkg::CFG_LOW_Z, 32'h8000_0000);
    cfg_write(mft_pkg::CFG_INV_X, 0);
    cfg_write(mft_pkg::CFG_INV_Y, 0);
    cfg_write(mft_pkg::CFG_INV_Z, 0);
    pend_q.push_back(score_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 2,
                              32'hFFFF_FFFF, 1));
    pend_q.push_back(score_at(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h2_0000, 32'h1_0000));
    pend_q.push_back(op_cmd(mft_pkg::OP_RECORD, 2, 0));  // saturated bin overflows the product
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 0, 14'(2 * 4096)));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 0, 14'(((0 * 16 + 1) * 16 + 2) * 16 + 3)));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 0, 14'(((1 * 16 + 5) * 16 + 5) * 16 + 5)));
    pend_q.push_back(op_cmd(mft_pkg::OP_READ, 0, 0));
    drain();

    // Other extreme: highest bound and finest cells.
    cfg_write(mft_pkg::CFG_LOW_X, 32'h7FFF_FFFF);
    cfg_write(mft_pkg::CFG_INV_X, 32'hFFFF_FFFF);
    pend_q.push_back(score_at(32'h7FFF_FFFF, 0, 0, 1, 32'h1_0000, 32'h1_0000));
    pend_q.push_back(score_at(32'h8000_0000, 0, 0, 1, 32'h1_0000, 32'h1_0000));
    push_random(60);
    drain();

    // Random phases over several mesh settings.
    for (int ph = 0; ph < 4; ph++) begin
      for (int r = 0; r < 6; r++) begin
        logic [31:0] v;
        if (ph == 0) v = (r < 3) ? 32'h0 : 32'h1_0000;
        else if (r < 3) v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        else v = $urandom_range(32'h2000, 32'h8_0000);
        cfg_write(mft_pkg::cfg_idx_t'(r), v);
      end
      push_random(ph == 1 ? 240 : 110);
      drain();
    end

    waited = 0;
    while (stats_q.size() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (200) @(negedge clk);
    $display("Covered %0d transfers in, %0d results, %0d mesh hits, %0d record sweeps.",
             n_accepted, n_results, n_hits, n_records);
    $display("Mesh settings: reset, both bound extremes, zero and full reciprocals, random.");
    if (n_fail == 0 && stats_q.size() == 0) begin
      $display("tb_mesh_flux_tally_running_stats_top OK");
    end else begin
      $display("tb_mesh_flux_tally_running_stats_top NOT OK");
    end
    $finish;
  end
endmodule
